FILE: hdl/wcp_pkg.sv
// shared types and constants of the wav chunk parser
package wcp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
    localparam logic [15:0] PCM_CODE = 16'd1;
    localparam logic [15:0] PCM_BITS = 16'd16;
    localparam logic [15:0] CHANNEL_SELECT_RESET = 16'd1;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK,
        PH_FMT,
        PH_SKIP,
        PH_DATA,
        PH_DRAIN
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_HEADER_SHORT = 4'd1,
        ST_NOT_RIFF     = 4'd2,
        ST_FMT_SMALL    = 4'd3,
        ST_FMT_SHORT    = 4'd4,
        ST_NO_FMT       = 4'd5,
        ST_NO_DATA      = 4'd6,
        ST_NOT_PCM      = 4'd7,
        ST_NOT_16BIT    = 4'd8,
        ST_BAD_CHANNEL  = 4'd9,
        ST_DATA_SHORT   = 4'd10
    } status_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } beat_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] sample;
        status_t            status;
        logic [31:0]        sample_rate;
        logic [15:0]        channel_count;
        logic [30:0]        frame_count;
        logic               last_result;
    } res_t;

    typedef struct packed {
        res_t       r0;
        res_t       r1;
        logic [1:0] n;
    } push_t;

endpackage

FILE: hdl/wcp_in_if.sv
// input byte channel
interface wcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       end_of_file;

    modport source (output valid, file_byte, end_of_file, input ready);
    modport sink (input valid, file_byte, end_of_file, output ready);
endinterface

FILE: hdl/wcp_out_if.sv
// result channel
interface wcp_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] sample;
    logic [3:0]         status;
    logic [31:0]        sample_rate;
    logic [15:0]        channel_count;
    logic [30:0]        frame_count;
    logic               last_result;

    modport source (output valid, kind, sample, status, sample_rate, channel_count,
                    frame_count, last_result, input ready);
    modport sink (input valid, kind, sample, status, sample_rate, channel_count,
                  frame_count, last_result, output ready);
endinterface

FILE: hdl/wcp_cfg_if.sv
// channel select write channel
interface wcp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: hdl/wav_chunk_parser_channel_extract_top.sv
// RIFF/WAVE parser takes one file byte per cycle through an input register,
// updates the parse state in one pass and writes zero, one or two results into
// a four-entry result queue; the result channel reads the queue head. A byte
// leaves the input register whenever the queue has at least two free entries,
// so with the result side ready the block sustains one byte per clock. A result
// is written into the queue when its byte leaves the input register and is
// presented from the queue head. channel_select can be written at any time
// over the cfg channel, which is always ready.
module wav_chunk_parser_channel_extract_top (
    input logic        clk,
    input logic        rst_n,
    wcp_cfg_if.sink    cfg,
    wcp_in_if.sink     in_ch,
    wcp_out_if.source  out_ch
);
    import wcp_pkg::*;

    beat_t in_beat;
    beat_t beat;
    logic  room;
    logic  go;
    push_t push;
    res_t  head;
    logic  head_valid;

    assign in_beat.file_byte   = in_ch.file_byte;
    assign in_beat.end_of_file = in_ch.end_of_file;
    assign cfg.ready           = 1'b1;

    wcp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_beat  (in_beat),
        .room     (room),
        .go       (go),
        .beat     (beat)
    );

    wcp_parse_core u_parse_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .beat     (beat),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.data),
        .push     (push)
    );

    wcp_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (head_valid),
        .pop        (out_ch.valid && out_ch.ready),
        .head       (head)
    );

    assign out_ch.valid         = head_valid;
    assign out_ch.kind          = head.kind;
    assign out_ch.sample        = head.sample;
    assign out_ch.status        = head.status;
    assign out_ch.sample_rate   = head.sample_rate;
    assign out_ch.channel_count = head.channel_count;
    assign out_ch.frame_count   = head.frame_count;
    assign out_ch.last_result   = head.last_result;

endmodule

FILE: hdl/wcp_in_stage.sv
// input register stage of the wav chunk parser
module wcp_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  wcp_pkg::beat_t in_beat,
    input  logic          room,
    output logic          go,
    output wcp_pkg::beat_t beat
);
    import wcp_pkg::*;

    logic  valid_reg;
    beat_t beat_reg;

    assign go       = valid_reg && room;
    assign in_ready = !valid_reg || go;
    assign beat     = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (go)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

FILE: hdl/wcp_parse_core.sv
// riff/wave parse state and per-byte result logic
module wcp_parse_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  wcp_pkg::beat_t beat,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_data,
    output wcp_pkg::push_t push
);
    import wcp_pkg::*;

    phase_t      phase_reg, phase_step, phase_next;
    logic [32:0] cnt_reg, cnt_step;
    logic [31:0] tag_reg, tag_step;
    logic [31:0] len_reg, len_step;
    logic        fmt_seen_reg, fmt_seen_step;
    logic [15:0] fmt_code_reg, fmt_code_step;
    logic [15:0] chan_reg, chan_step;
    logic [31:0] rate_reg, rate_step;
    logic [15:0] bits_reg, bits_step;
    logic [31:0] rem_reg, rem_step;
    logic [16:0] fpos_reg, fpos_step;
    logic [7:0]  low_reg, low_step;
    logic [30:0] frames_reg, frames_step;
    logic [15:0] sel_reg;

    logic [7:0]  b;
    logic        eof;
    logic [31:0] tag_sh_lo, tag_sh_hi, len_cat, rem_cat, len_less16;
    logic        hdr_last, hdr_ok, chunk_last, is_fmt, is_data, fmt_last, skip_last;
    logic [32:0] skip_chunk, skip_fmt;
    logic        chk_emit;
    status_t     chk_code;
    logic        sel_ok, at_low, at_high, whole, data_last, smp_emit;
    logic [16:0] target, frame_bytes, fpos_inc;
    logic        st_step;
    status_t     st_step_code, eof_code, st_code;
    logic        st_valid;
    res_t        smp_res, stat_res;

    // decode
    always_comb
    begin
        b          = beat.file_byte;
        eof        = beat.end_of_file;
        tag_sh_lo  = {tag_reg[23:0], b};
        tag_sh_hi  = {b, tag_reg[31:8]};
        len_cat    = {b, len_reg[31:8]};
        rem_cat    = {b, rem_reg[31:8]};
        hdr_last   = cnt_reg == 33'd11;
        hdr_ok     = (len_reg == TAG_RIFF) && (tag_sh_lo == TAG_WAVE);
        chunk_last = cnt_reg == 33'd7;
        is_fmt     = tag_reg == TAG_FMT;
        is_data    = tag_reg == TAG_DATA;
        fmt_last   = cnt_reg == 33'd15;
        skip_last  = cnt_reg == 33'd1;
        skip_chunk = {1'b0, len_cat} + {32'd0, len_cat[0]};
        len_less16 = len_reg - FMT_BODY_BYTES;
        skip_fmt   = {1'b0, len_less16} + {32'd0, len_reg[0]};
        sel_ok      = (sel_reg != 16'd0) && (sel_reg <= chan_reg);
        target      = {sel_reg - 16'd1, 1'b0};
        frame_bytes = {chan_reg, 1'b0};
        fpos_inc    = fpos_reg + 17'd1;
        at_low      = fpos_reg == target;
        at_high     = fpos_reg == (target + 17'd1);
        whole       = ({1'b0, rem_reg} + {16'd0, fpos_reg}) >= {16'd0, frame_bytes};
        data_last   = rem_reg == 32'd1;
        smp_emit    = (phase_reg == PH_DATA) && sel_ok && !at_low && at_high && whole;

        chk_emit = 1'b0;
        chk_code = ST_OK;
        if (is_fmt)
        begin
            if (len_cat < FMT_BODY_BYTES)
            begin
                chk_emit = 1'b1;
                chk_code = ST_FMT_SMALL;
            end
        end
        else if (is_data)
        begin
            chk_emit = 1'b1;
            priority if (!fmt_seen_reg)
                chk_code = ST_NO_FMT;
            else if (fmt_code_reg != PCM_CODE)
                chk_code = ST_NOT_PCM;
            else if (bits_reg != PCM_BITS)
                chk_code = ST_NOT_16BIT;
            else if (!sel_ok)
                chk_code = ST_BAD_CHANNEL;
            else if (len_cat == 32'd0)
                chk_code = ST_OK;
            else
                chk_emit = 1'b0;
        end

        st_step      = 1'b0;
        st_step_code = ST_OK;
        unique case (phase_reg)
            PH_HEADER:
            begin
                st_step      = hdr_last && !hdr_ok;
                st_step_code = ST_NOT_RIFF;
            end
            PH_CHUNK:
            begin
                st_step      = chunk_last && chk_emit;
                st_step_code = chk_code;
            end
            PH_DATA:
            begin
                st_step      = data_last;
                st_step_code = ST_OK;
            end
            default:
            begin
                st_step      = 1'b0;
                st_step_code = ST_OK;
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_step = phase_reg;
        unique case (phase_reg)
            PH_HEADER:
                if (hdr_last)
                    phase_step = hdr_ok ? PH_CHUNK : PH_DRAIN;
            PH_CHUNK:
                if (chunk_last)
                begin
                    priority if (chk_emit)
                        phase_step = PH_DRAIN;
                    else if (is_fmt)
                        phase_step = PH_FMT;
                    else if (is_data)
                        phase_step = PH_DATA;
                    else
                        phase_step = (skip_chunk == 33'd0) ? PH_CHUNK : PH_SKIP;
                end
            PH_FMT:
                if (fmt_last)
                    phase_step = (skip_fmt == 33'd0) ? PH_CHUNK : PH_SKIP;
            PH_SKIP:
                if (skip_last)
                    phase_step = PH_CHUNK;
            PH_DATA:
                if (data_last)
                    phase_step = PH_DRAIN;
            default:
                phase_step = PH_DRAIN;
        endcase
        phase_next = eof ? PH_HEADER : phase_step;
    end

    // datapath
    always_comb
    begin
        cnt_step      = cnt_reg;
        tag_step      = tag_reg;
        len_step      = len_reg;
        fmt_seen_step = fmt_seen_reg;
        fmt_code_step = fmt_code_reg;
        chan_step     = chan_reg;
        rate_step     = rate_reg;
        bits_step     = bits_reg;
        rem_step      = rem_reg;
        fpos_step     = fpos_reg;
        low_step      = low_reg;
        frames_step   = frames_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                tag_step = tag_sh_lo;
                if (cnt_reg == 33'd3)
                    len_step = tag_sh_lo;
                cnt_step = hdr_last ? 33'd0 : cnt_reg + 33'd1;
            end
            PH_CHUNK:
            begin
                if (cnt_reg < 33'd4)
                    tag_step = tag_sh_lo;
                else
                    len_step = len_cat;
                cnt_step = cnt_reg + 33'd1;
                if (chunk_last)
                begin
                    cnt_step = 33'd0;
                    if (is_data && !chk_emit)
                    begin
                        rem_step  = len_cat;
                        fpos_step = 17'd0;
                    end
                    else if (!is_fmt && !is_data)
                        cnt_step = skip_chunk;
                end
            end
            PH_FMT:
            begin
                if (cnt_reg < 33'd4)
                    tag_step = tag_sh_hi;
                else if (cnt_reg < 33'd8)
                    rem_step = rem_cat;
                else if (cnt_reg == 33'd14)
                    low_step = b;
                if (fmt_last)
                begin
                    fmt_code_step = tag_reg[15:0];
                    chan_step     = tag_reg[31:16];
                    rate_step     = rem_reg;
                    bits_step     = {b, low_reg};
                    fmt_seen_step = 1'b1;
                    rem_step      = 32'd0;
                    cnt_step      = skip_fmt;
                end
                else
                    cnt_step = cnt_reg + 33'd1;
            end
            PH_SKIP:
                cnt_step = cnt_reg - 33'd1;
            PH_DATA:
            begin
                if (sel_ok && at_low)
                    low_step = b;
                if (smp_emit)
                    frames_step = frames_reg + 31'd1;
                fpos_step = (fpos_inc >= frame_bytes) ? 17'd0 : fpos_inc;
                rem_step  = rem_reg - 32'd1;
            end
            default:
                cnt_step = cnt_reg;
        endcase
    end

    // results
    always_comb
    begin
        priority if (phase_step == PH_HEADER)
            eof_code = ST_HEADER_SHORT;
        else if (phase_step == PH_FMT)
            eof_code = ST_FMT_SHORT;
        else if (phase_step == PH_DATA)
            eof_code = ST_DATA_SHORT;
        else
            eof_code = fmt_seen_step ? ST_NO_DATA : ST_NO_FMT;

        st_valid = st_step || (eof && (phase_step != PH_DRAIN));
        st_code  = st_step ? st_step_code : eof_code;

        smp_res               = '0;
        smp_res.kind          = KIND_SAMPLE;
        smp_res.sample        = {b, low_reg};
        smp_res.status        = ST_OK;

        stat_res               = '0;
        stat_res.kind          = KIND_STATUS;
        stat_res.status        = st_code;
        stat_res.sample_rate   = rate_step;
        stat_res.channel_count = chan_step;
        stat_res.frame_count   = frames_step;
        stat_res.last_result   = 1'b1;

        push.r0 = smp_emit ? smp_res : stat_res;
        push.r1 = stat_res;
        push.n  = go ? ({1'b0, smp_emit} + {1'b0, st_valid}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            cnt_reg      <= '0;
            tag_reg      <= '0;
            len_reg      <= '0;
            fmt_seen_reg <= 1'b0;
            fmt_code_reg <= '0;
            chan_reg     <= '0;
            rate_reg     <= '0;
            bits_reg     <= '0;
            rem_reg      <= '0;
            fpos_reg     <= '0;
            low_reg      <= '0;
            frames_reg   <= '0;
        end
        else if (go)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= eof ? '0 : cnt_step;
            tag_reg      <= eof ? '0 : tag_step;
            len_reg      <= eof ? '0 : len_step;
            fmt_seen_reg <= eof ? 1'b0 : fmt_seen_step;
            fmt_code_reg <= eof ? '0 : fmt_code_step;
            chan_reg     <= eof ? '0 : chan_step;
            rate_reg     <= eof ? '0 : rate_step;
            bits_reg     <= eof ? '0 : bits_step;
            rem_reg      <= eof ? '0 : rem_step;
            fpos_reg     <= eof ? '0 : fpos_step;
            low_reg      <= eof ? '0 : low_step;
            frames_reg   <= eof ? '0 : frames_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= CHANNEL_SELECT_RESET;
        end
        else if (cfg_we)
        begin
            sel_reg <= cfg_data;
        end
    end

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        go && eof |=> phase_reg == PH_HEADER && frames_reg == 31'd0)
        else $error("parser did not restart after end of file");

    a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        go && phase_reg == PH_DRAIN && !eof |-> push.n == 2'd0)
        else $error("result produced while draining");

    a_two_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> smp_emit && push.r1.kind == KIND_STATUS)
        else $error("two results without a sample");

endmodule

FILE: hdl/wcp_out_queue.sv
// small result queue between the parser and the result channel
module wcp_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  wcp_pkg::push_t push,
    output logic           room,
    output logic           head_valid,
    input  logic           pop,
    output wcp_pkg::res_t  head
);
    import wcp_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    res_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, wr_ptr_inc;
    logic [CNT_W-1:0] count_reg, count_next;

    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
    assign count_next = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    assign room       = count_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> room)
        else $error("push into a full result queue");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from an empty result queue");

endmodule
